[hdl/gbts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared constants and codes of the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

	localparam int CAPACITY  = 4096;
	localparam int CHAR_BITS = 16;
	localparam int ADDR_W    = $clog2(CAPACITY);

	localparam int KIND_W = 2;
	localparam int POS_W  = 13;
	localparam int CHAR_W = 16;
	localparam int STAT_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

endpackage
`default_nettype wire

[hdl/gbts_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_if
// Request and response channels of the gap buffer text store.
// ----------------------------------------------------------------------------
interface gbts_req_if;
	import gbts_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  position;
	logic [POS_W-1:0]  count;
	logic [CHAR_W-1:0] char_in;
	logic              run_last;

	modport source (output valid, kind, position, count, char_in, run_last, input ready);
	modport sink   (input valid, kind, position, count, char_in, run_last, output ready);
endinterface

interface gbts_rsp_if;
	import gbts_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [CHAR_W-1:0] char_out;
	logic [POS_W-1:0]  text_length;

	modport source (output valid, status, char_out, text_length, input ready);
	modport sink   (input valid, status, char_out, text_length, output ready);
endinterface
`default_nettype wire

[hdl/gbts_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/gap_buffer_text_store_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gap_buffer_text_store_top
// Fixed-capacity gap buffer of characters with insert runs, range delete
// and single-character read.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake      Payload
//   -------  ---  -------------  --------------------------------------------
//   req      in   valid / ready  kind, position, count, char_in, run_last
//   rsp      out  valid / ready  status, char_out, text_length
//
// Sequence: read DECODE, READ, RDWAIT, FINISH; insert in an open run DECODE,
// INSERT, FINISH; invalid item or read at the text end DECODE, FINISH; run start
// or delete DECODE, SHIFT to the position, INSERT or DELETE, FINISH, then IDLE.
// Reset: arst_n sets gap start to 0 and gap end to CAPACITY, and clears the text length, run flag and sequencer.
// Stalls: a result waits in the output register; the next one holds until taken.
//
module gap_buffer_text_store_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gbts_req_if.sink   req,
	gbts_rsp_if.source rsp
);
	import gbts_pkg::*;

	// Sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_SHIFT  = 3'd2;
	localparam logic [2:0] ST_INSERT = 3'd3;
	localparam logic [2:0] ST_DELETE = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_RDWAIT = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	logic [2:0] state_q;

	// Gap and text bookkeeping
	logic [POS_W-1:0] gap_start_q;
	logic [POS_W-1:0] gap_end_q;
	logic [POS_W-1:0] text_end_q;
	logic             in_run_q;

	// Latched request item
	logic [KIND_W-1:0] kind_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  cnt_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	// Working registers
	logic [POS_W-1:0]  phys_q;
	logic              wr_pend_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [STAT_W-1:0] res_status_q;
	logic [CHAR_W-1:0] res_char_q;

	// Output register
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [POS_W-1:0]  out_len_q;

	// Store ports
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [CHAR_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [CHAR_BITS-1:0] ram_rdata;

	logic             req_fire;
	logic             out_free;
	logic             shift_left;
	logic             shift_right;
	logic [POS_W-1:0] gs_dec;
	logic [POS_W-1:0] ge_dec;
	logic             ins_ok;
	logic [POS_W:0]   del_end;

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	// Shared gap-move unit: two compares steer the gap one character a cycle
	assign shift_left  = gap_start_q > pos_q;
	assign shift_right = gap_start_q < pos_q;
	assign gs_dec      = gap_start_q - POS_W'(1);
	assign ge_dec      = gap_end_q - POS_W'(1);
	assign ins_ok      = gap_end_q > gap_start_q;
	assign del_end     = {1'b0, pos_q} + {1'b0, cnt_q};

	// Read address: gap-move source while shifting, translated position on read
	always_comb begin
		if (state_q == ST_SHIFT) begin
			ram_raddr = shift_left ? gs_dec[ADDR_W-1:0] : gap_end_q[ADDR_W-1:0];
		end else begin
			ram_raddr = phys_q[ADDR_W-1:0];
		end
	end

	// Write port: finish a pending copy, or store the inserted character
	always_comb begin
		if (wr_pend_q) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_q;
			ram_wdata = ram_rdata;
		end else begin
			ram_we    = (state_q == ST_INSERT) && ins_ok;
			ram_waddr = gap_start_q[ADDR_W-1:0];
			ram_wdata = CHAR_BITS'(char_q);
		end
	end

	gbts_ram #(
		.WIDTH (CHAR_BITS),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Latched item and working payload: no reset needed
	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q <= req.kind;
			pos_q  <= req.position;
			cnt_q  <= req.count;
			char_q <= req.char_in;
			last_q <= req.run_last;
		end
		if (state_q == ST_SHIFT) begin
			wr_addr_q <= shift_left ? ge_dec[ADDR_W-1:0] : gap_start_q[ADDR_W-1:0];
		end
		if (state_q == ST_DECODE) begin
			// Translate across the gap for a read
			if (pos_q >= gap_start_q) begin
				phys_q <= pos_q + (gap_end_q - gap_start_q);
			end else begin
				phys_q <= pos_q;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_status_q <= res_status_q;
			out_char_q   <= res_char_q;
			out_len_q    <= text_end_q;
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gap_start_q  <= '0;
			gap_end_q    <= POS_W'(CAPACITY);
			text_end_q   <= '0;
			in_run_q     <= 1'b0;
			wr_pend_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			res_status_q <= STAT_OK;
			res_char_q   <= '0;
		end else begin
			// A gap-move step leaves its copy write for the next cycle
			wr_pend_q <= (state_q == ST_SHIFT) && (shift_left || shift_right);

			// Load the output register on finish, else drop a result once taken
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					res_char_q <= '0;
					case (kind_q)
						KIND_INSERT: begin
							if (in_run_q) begin
								res_status_q <= STAT_OK;
								state_q      <= ST_INSERT;
							end else if (pos_q > text_end_q) begin
								res_status_q <= STAT_BAD_POS;
								state_q      <= ST_FINISH;
							end else begin
								res_status_q <= STAT_OK;
								state_q      <= ST_SHIFT;
							end
						end
						KIND_DELETE: begin
							in_run_q <= 1'b0;
							if (pos_q > text_end_q || del_end > {1'b0, text_end_q}) begin
								res_status_q <= STAT_BAD_POS;
								state_q      <= ST_FINISH;
							end else begin
								res_status_q <= STAT_OK;
								state_q      <= ST_SHIFT;
							end
						end
						KIND_READ: begin
							in_run_q <= 1'b0;
							if (pos_q > text_end_q) begin
								res_status_q <= STAT_BAD_POS;
								state_q      <= ST_FINISH;
							end else if (pos_q == text_end_q) begin
								res_status_q <= STAT_OK;
								state_q      <= ST_FINISH;
							end else begin
								res_status_q <= STAT_OK;
								state_q      <= ST_READ;
							end
						end
						default: begin
							res_status_q <= STAT_BAD_POS;
							state_q      <= ST_FINISH;
						end
					endcase
				end
				ST_SHIFT: begin
					// Advance the gap one character; the copy's write lands next cycle
					if (shift_left) begin
						gap_start_q <= gs_dec;
						gap_end_q   <= ge_dec;
					end else if (shift_right) begin
						gap_start_q <= gap_start_q + POS_W'(1);
						gap_end_q   <= gap_end_q + POS_W'(1);
					end else begin
						state_q <= (kind_q == KIND_INSERT) ? ST_INSERT : ST_DELETE;
					end
				end
				ST_INSERT: begin
					if (ins_ok) begin
						gap_start_q <= gap_start_q + POS_W'(1);
						text_end_q  <= text_end_q + POS_W'(1);
					end else begin
						res_status_q <= STAT_FULL;
					end
					in_run_q <= !last_q;
					state_q  <= ST_FINISH;
				end
				ST_DELETE: begin
					gap_end_q  <= gap_end_q + cnt_q;
					text_end_q <= text_end_q - cnt_q;
					state_q    <= ST_FINISH;
				end
				ST_READ: begin
					state_q <= ST_RDWAIT;
				end
				ST_RDWAIT: begin
					res_char_q <= CHAR_W'(ram_rdata);
					state_q    <= ST_FINISH;
				end
				ST_FINISH: begin
					// Hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.char_out    = out_char_q;
	assign rsp.text_length = out_len_q;

	// The gap never inverts
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		gap_start_q <= gap_end_q)
		else $error("gap start beyond gap end");

	// Text before the gap plus text after it equals the text length
	a_len_sum: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, text_end_q} + {1'b0, gap_end_q}) ==
		({1'b0, gap_start_q} + (POS_W+1)'(CAPACITY)))
		else $error("text length out of step with gap pointers");

	// A pending copy write only follows a gap-move step
	a_pend_shift: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_q |-> (state_q == ST_SHIFT && $past(state_q) == ST_SHIFT))
		else $error("copy write outside gap move");

	// An accepted item always moves the sequencer from idle to decode
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == ST_DECODE))
		else $error("accept did not start decode");

endmodule
`default_nettype wire
